FILE: design/stk500v1_isp_command_engine_core_assert.svh
// Assertion macros shared by the command engine.
`ifndef STK500V1_ISP_COMMAND_ENGINE_CORE_ASSERT_SVH
`define STK500V1_ISP_COMMAND_ENGINE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define ISP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define ISP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ISP_ASSERT_IMP(lbl, ante, cons, msg)
`define ISP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/stk_isp_pkg.sv
package stk_isp_pkg;

	localparam int DEF_BUFFER_DEPTH = 256;
	localparam int DEF_EEPROM_CHUNK = 32;
	localparam int MAX_RES = 10;

	// host reply codes
	localparam logic [7:0] R_OK      = 8'h10;
	localparam logic [7:0] R_FAILED  = 8'h11;
	localparam logic [7:0] R_UNKNOWN = 8'h12;
	localparam logic [7:0] R_INSYNC  = 8'h14;
	localparam logic [7:0] R_NOSYNC  = 8'h15;
	localparam logic [7:0] EOP       = 8'h20;

	// host commands
	localparam logic [7:0] CMD_SYNC      = 8'h30;
	localparam logic [7:0] CMD_SIGN_ON   = 8'h31;
	localparam logic [7:0] CMD_GET_PARM  = 8'h41;
	localparam logic [7:0] CMD_SET_DEV   = 8'h42;
	localparam logic [7:0] CMD_SET_DEVX  = 8'h45;
	localparam logic [7:0] CMD_ENTER_PGM = 8'h50;
	localparam logic [7:0] CMD_LEAVE_PGM = 8'h51;
	localparam logic [7:0] CMD_LOAD_ADDR = 8'h55;
	localparam logic [7:0] CMD_UNIVERSAL = 8'h56;
	localparam logic [7:0] CMD_PROG_FL   = 8'h60;
	localparam logic [7:0] CMD_PROG_DATA = 8'h61;
	localparam logic [7:0] CMD_PROG_PAGE = 8'h64;
	localparam logic [7:0] CMD_READ_PAGE = 8'h74;
	localparam logic [7:0] CMD_READ_SIG  = 8'h75;

	// parameter queries
	localparam logic [7:0] PARM_HW    = 8'h80;
	localparam logic [7:0] PARM_SWMAJ = 8'h81;
	localparam logic [7:0] PARM_SWMIN = 8'h82;
	localparam logic [7:0] PARM_PTYPE = 8'h93;

	// memory kinds
	localparam logic [1:0] MEM_NONE   = 2'd0;
	localparam logic [1:0] MEM_FLASH  = 2'd1;
	localparam logic [1:0] MEM_EEPROM = 2'd2;

	// result kinds
	localparam logic [1:0] OK_HOST  = 2'd0;
	localparam logic [1:0] OK_FRAME = 2'd1;
	localparam logic [1:0] OK_RESET = 2'd2;
	localparam logic [1:0] OK_SPIEN = 2'd3;

	// config register indexes
	localparam logic [1:0] CFG_HW    = 2'd0;
	localparam logic [1:0] CFG_SWMAJ = 2'd1;
	localparam logic [1:0] CFG_SWMIN = 2'd2;

	// SPI instructions
	localparam logic [7:0] SPI_PGM_EN  = 8'hAC;
	localparam logic [7:0] SPI_PGM_EN2 = 8'h53;
	localparam logic [7:0] SPI_LD_LO   = 8'h40;
	localparam logic [7:0] SPI_LD_HI   = 8'h48;
	localparam logic [7:0] SPI_COMMIT  = 8'h4C;
	localparam logic [7:0] SPI_RD_LO   = 8'h20;
	localparam logic [7:0] SPI_RD_HI   = 8'h28;
	localparam logic [7:0] SPI_EE_WR   = 8'hC0;
	localparam logic [7:0] SPI_EE_RD   = 8'hA0;
	localparam logic [7:0] SPI_SIG     = 8'h30;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] hb;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic       lvl;
		logic       last;
	} res_t;

	function automatic res_t mk_host(input logic [7:0] b);
		res_t r;
		r = '0;
		r.kind = OK_HOST;
		r.hb = b;
		return r;
	endfunction

	function automatic res_t mk_frame(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		res_t r;
		r = '0;
		r.kind = OK_FRAME;
		r.b0 = a;
		r.b1 = b;
		r.b2 = c;
		r.b3 = d;
		return r;
	endfunction

	function automatic res_t mk_line(input logic [1:0] k, input logic l);
		res_t r;
		r = '0;
		r.kind = k;
		r.lvl = l;
		return r;
	endfunction

	// sign-on text
	function automatic logic [7:0] id_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h41;
			3'd1: c = 8'h56;
			3'd2: c = 8'h52;
			3'd3: c = 8'h20;
			3'd4: c = 8'h49;
			3'd5: c = 8'h53;
			3'd6: c = 8'h50;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: design/stk_isp_ram.sv
module stk_isp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/stk500v1_isp_command_engine_core.sv
// In-system programmer command engine speaking STK500 version 1. Input transfers carry one byte
// each: tuser low is a host link byte, tuser high is the reply byte of the last SPI frame sent
// (a byte of the wrong kind for the current phase is dropped with no result). Each input byte
// is registered, then decoded into up to ten results that drain one per cycle while
// m_axis_tready is high from an output shift buffer: host bytes, four-byte SPI frames,
// reset line levels and SPI enables; tlast marks the last result of a byte. A byte that
// yields at most one result lets the next byte follow at once while the output is ready;
// a byte that yields more holds the input side while the output buffer drains. The page
// buffer is a RAM with registered read whose next address is predicted from the state, so no read stall.
`include "stk500v1_isp_command_engine_core_assert.svh"

module stk500v1_isp_command_engine_core #(
	parameter int BUFFER_DEPTH = stk_isp_pkg::DEF_BUFFER_DEPTH,
	parameter int EEPROM_CHUNK = stk_isp_pkg::DEF_EEPROM_CHUNK
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data[7:0]
	input  logic        s_axis_tuser,  // req_type[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // host_byte[7:0] spi_b0[15:8] spi_b1[23:16]
	                                   // spi_b2[31:24] spi_b3[39:32] line_level[40]
	output logic [1:0]  m_axis_tuser,  // out_kind[1:0]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [15:0] CHUNK16 = 16'(EEPROM_CHUNK);
	localparam int NR = stk_isp_pkg::MAX_RES;

	localparam logic [4:0] PH_IDLE        = 5'd0;
	localparam logic [4:0] PH_EOP_EMPTY   = 5'd1;
	localparam logic [4:0] PH_EOP_BYTE    = 5'd2;
	localparam logic [4:0] PH_EOP_ID      = 5'd3;
	localparam logic [4:0] PH_VER         = 5'd4;
	localparam logic [4:0] PH_FILL        = 5'd5;
	localparam logic [4:0] PH_ADDR_LO     = 5'd6;
	localparam logic [4:0] PH_ADDR_HI     = 5'd7;
	localparam logic [4:0] PH_SKIP        = 5'd8;
	localparam logic [4:0] PH_LEN_HI      = 5'd9;
	localparam logic [4:0] PH_LEN_LO      = 5'd10;
	localparam logic [4:0] PH_MEMTYPE     = 5'd11;
	localparam logic [4:0] PH_EOP_READ    = 5'd12;
	localparam logic [4:0] PH_EOP_SIG     = 5'd13;
	localparam logic [4:0] PH_EOP_UNKNOWN = 5'd14;
	localparam logic [4:0] PH_EOP_FLASH   = 5'd15;
	localparam logic [4:0] PH_EOP_EEPROM  = 5'd16;
	localparam logic [4:0] PH_SPI_PMODE   = 5'd17;
	localparam logic [4:0] PH_SPI_UNIV    = 5'd18;
	localparam logic [4:0] PH_FW_LO       = 5'd19;
	localparam logic [4:0] PH_FW_HI       = 5'd20;
	localparam logic [4:0] PH_FW_COMMIT   = 5'd21;
	localparam logic [4:0] PH_FW_FINAL    = 5'd22;
	localparam logic [4:0] PH_EEW         = 5'd23;
	localparam logic [4:0] PH_FR_LO       = 5'd24;
	localparam logic [4:0] PH_FR_HI       = 5'd25;
	localparam logic [4:0] PH_ER          = 5'd26;
	localparam logic [4:0] PH_SIG         = 5'd27;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x, input logic [1:0] k);
		logic [AW:0] s;
		s = {1'b0, x} + (AW+1)'(k);
		if (s >= (AW+1)'(BUFFER_DEPTH)) begin
			s = s - (AW+1)'(BUFFER_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] x);
		logic [AW-1:0] r;
		if (x == '0) begin
			r = AW'(BUFFER_DEPTH - 1);
		end else begin
			r = x - AW'(1);
		end
		return r;
	endfunction

	function automatic logic [15:0] fill_tgt(input logic [7:0] c, input logic [1:0] m,
		input logic [15:0] t);
		logic [15:0] r;
		r = t;
		if (c == stk_isp_pkg::CMD_PROG_PAGE && m == stk_isp_pkg::MEM_EEPROM && t > CHUNK16) begin
			r = CHUNK16;
		end
		return r;
	endfunction

	function automatic logic [15:0] cur_page(input logic [15:0] ps, input logic [15:0] wa);
		logic [15:0] r;
		case (ps)
			16'd32:  r = wa & 16'hFFF0;
			16'd64:  r = wa & 16'hFFE0;
			16'd128: r = wa & 16'hFFC0;
			16'd256: r = wa & 16'hFF80;
			default: r = wa;
		endcase
		return r;
	endfunction

	// input register
	logic       in_v_s1;
	logic       in_type_s1;
	logic [7:0] in_data_s1;

	// engine state
	logic [7:0]  cmd_q, cmd_n;
	logic [4:0]  phase_q, phase_n;
	logic [15:0] wa_q, wa_n;
	logic [15:0] bi_q, bi_n;
	logic [AW-1:0] bidx_q, bidx_n;
	logic [15:0] tl_q, tl_n;
	logic [1:0]  mk_q, mk_n;
	logic [7:0]  dev_q, dev_n;
	logic [15:0] ps_q, ps_n;
	logic [15:0] es_q, es_n;
	logic [15:0] err_q, err_n;
	logic        pm_q, pm_n;
	logic [15:0] op_q, op_n;
	logic [15:0] cs_q, cs_n;
	logic [7:0]  held_q, held_n;
	logic [7:0]  hw_q, swmaj_q, swmin_q;

	// copies of the parameter block bytes 0..3 and 12..15
	logic [7:0] pb_q [8];
	logic [7:0] pbw [8];

	stk_isp_pkg::res_t res [NR];
	logic [3:0]        res_cnt;
	stk_isp_pkg::res_t obuf_q [NR];
	logic [3:0]        obuf_cnt_q;

	logic          m_fire, step_fire, waiting, fill_we;
	logic [AW-1:0] raddr, pred_ph_addr;
	logic [7:0]    ram_rdata, rd_byte, byp_d_q;
	logic          byp_q;

	assign m_axis_tvalid = obuf_cnt_q != 4'd0;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign step_fire = in_v_s1 && (obuf_cnt_q == 4'd0 || (obuf_cnt_q == 4'd1 && m_fire));
	assign s_axis_tready = !in_v_s1 || step_fire;
	assign waiting = phase_q >= PH_SPI_PMODE;
	assign fill_we = !in_type_s1 && !waiting && phase_q == PH_FILL;
	assign rd_byte = byp_q ? byp_d_q : ram_rdata;

	assign pbw[0] = (fill_we && bidx_q == AW'(0))  ? in_data_s1 : pb_q[0];
	assign pbw[1] = (fill_we && bidx_q == AW'(1))  ? in_data_s1 : pb_q[1];
	assign pbw[2] = (fill_we && bidx_q == AW'(2))  ? in_data_s1 : pb_q[2];
	assign pbw[3] = (fill_we && bidx_q == AW'(3))  ? in_data_s1 : pb_q[3];
	assign pbw[4] = (fill_we && bidx_q == AW'(12)) ? in_data_s1 : pb_q[4];
	assign pbw[5] = (fill_we && bidx_q == AW'(13)) ? in_data_s1 : pb_q[5];
	assign pbw[6] = (fill_we && bidx_q == AW'(14)) ? in_data_s1 : pb_q[6];
	assign pbw[7] = (fill_we && bidx_q == AW'(15)) ? in_data_s1 : pb_q[7];

	always_comb begin
		logic        sf, fd, ah;
		logic [3:0]  rn;
		logic [15:0] ea;
		logic [7:0]  d, buf0;
		sf = 1'b0;
		fd = 1'b0;
		rn = 4'd0;
		d = in_data_s1;
		ah = dev_q >= 8'hE0;
		ea = '0;
		buf0 = (fill_we && bidx_q == '0) ? in_data_s1 : rd_byte;
		for (int i = 0; i < NR; i++) begin
			res[i] = '0;
		end
		cmd_n = cmd_q;
		phase_n = phase_q;
		wa_n = wa_q;
		bi_n = bi_q;
		bidx_n = bidx_q;
		tl_n = tl_q;
		mk_n = mk_q;
		dev_n = dev_q;
		ps_n = ps_q;
		es_n = es_q;
		err_n = err_q;
		pm_n = pm_q;
		op_n = op_q;
		cs_n = cs_q;
		held_n = held_q;

		if (in_type_s1 && waiting) begin
			case (phase_q)
				PH_SPI_PMODE: begin
					pm_n = 1'b1;
					phase_n = PH_EOP_EMPTY;
				end
				PH_SPI_UNIV: begin
					held_n = d;
					phase_n = PH_EOP_BYTE;
				end
				PH_FW_LO: begin
					res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_LD_HI, wa_q[15:8],
						wa_q[7:0], rd_byte);
					rn = rn + 4'd1;
					phase_n = PH_FW_HI;
				end
				PH_FW_HI: begin
					wa_n = wa_q + 16'd1;
					if ({1'b0, bi_q} + 17'd2 < {1'b0, tl_q}) begin
						bi_n = bi_q + 16'd2;
						bidx_n = wrap_inc(bidx_q, 2'd2);
						if (op_q != cur_page(ps_q, wa_n)) begin
							res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_COMMIT, op_q[15:8],
								op_q[7:0], 8'h00);
							rn = rn + 4'd1;
							phase_n = PH_FW_COMMIT;
						end else begin
							res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_LD_LO, wa_n[15:8],
								wa_n[7:0], rd_byte);
							rn = rn + 4'd1;
							phase_n = PH_FW_LO;
						end
					end else begin
						res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_COMMIT, op_q[15:8],
							op_q[7:0], 8'h00);
						rn = rn + 4'd1;
						phase_n = PH_FW_FINAL;
					end
				end
				PH_FW_COMMIT: begin
					op_n = cur_page(ps_q, wa_q);
					res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_LD_LO, wa_q[15:8],
						wa_q[7:0], rd_byte);
					rn = rn + 4'd1;
					phase_n = PH_FW_LO;
				end
				PH_FW_FINAL: begin
					res[rn] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
					rn = rn + 4'd1;
					phase_n = PH_IDLE;
				end
				PH_EEW: begin
					bi_n = bi_q + 16'd1;
					bidx_n = wrap_inc(bidx_q, 2'd1);
					if (bi_n < fill_tgt(cmd_q, mk_q, tl_q)) begin
						ea = cs_q + bi_n;
						res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_EE_WR, ea[15:8],
							ea[7:0], rd_byte);
						rn = rn + 4'd1;
						phase_n = PH_EEW;
					end else if (tl_q > CHUNK16) begin
						tl_n = tl_q - CHUNK16;
						cs_n = cs_q + CHUNK16;
						sf = 1'b1;
					end else begin
						held_n = stk_isp_pkg::R_OK;
						phase_n = PH_EOP_EEPROM;
					end
				end
				PH_FR_LO: begin
					res[rn] = stk_isp_pkg::mk_host(d);
					rn = rn + 4'd1;
					res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_RD_HI, wa_q[15:8],
						wa_q[7:0], 8'h00);
					rn = rn + 4'd1;
					phase_n = PH_FR_HI;
				end
				PH_FR_HI: begin
					res[rn] = stk_isp_pkg::mk_host(d);
					rn = rn + 4'd1;
					wa_n = wa_q + 16'd1;
					if ({1'b0, bi_q} + 17'd2 < {1'b0, tl_q}) begin
						bi_n = bi_q + 16'd2;
						bidx_n = wrap_inc(bidx_q, 2'd2);
						res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_RD_LO, wa_n[15:8],
							wa_n[7:0], 8'h00);
						rn = rn + 4'd1;
						phase_n = PH_FR_LO;
					end else begin
						res[rn] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
						rn = rn + 4'd1;
						phase_n = PH_IDLE;
					end
				end
				PH_ER: begin
					res[rn] = stk_isp_pkg::mk_host(d);
					rn = rn + 4'd1;
					bi_n = bi_q + 16'd1;
					bidx_n = wrap_inc(bidx_q, 2'd1);
					if (bi_n < tl_q) begin
						ea = cs_q + bi_n;
						res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_EE_RD, ea[15:8],
							ea[7:0], 8'hFF);
						rn = rn + 4'd1;
						phase_n = PH_ER;
					end else begin
						res[rn] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
						rn = rn + 4'd1;
						phase_n = PH_IDLE;
					end
				end
				PH_SIG: begin
					res[rn] = stk_isp_pkg::mk_host(d);
					rn = rn + 4'd1;
					bi_n = bi_q + 16'd1;
					bidx_n = wrap_inc(bidx_q, 2'd1);
					if (bi_n < 16'd3) begin
						res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_SIG, 8'h00,
							bi_n[7:0], 8'h00);
						rn = rn + 4'd1;
						phase_n = PH_SIG;
					end else begin
						res[rn] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
						rn = rn + 4'd1;
						phase_n = PH_IDLE;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end else if (!in_type_s1 && !waiting) begin
			case (phase_q)
				PH_IDLE: begin
					cmd_n = d;
					case (d)
						stk_isp_pkg::CMD_SYNC: begin
							err_n = '0;
							phase_n = PH_EOP_EMPTY;
						end
						stk_isp_pkg::CMD_SIGN_ON: phase_n = PH_EOP_ID;
						stk_isp_pkg::CMD_GET_PARM: phase_n = PH_VER;
						stk_isp_pkg::CMD_SET_DEV: begin
							tl_n = 16'd20;
							sf = 1'b1;
						end
						stk_isp_pkg::CMD_SET_DEVX: begin
							tl_n = 16'd5;
							sf = 1'b1;
						end
						stk_isp_pkg::CMD_UNIVERSAL: begin
							tl_n = 16'd4;
							sf = 1'b1;
						end
						stk_isp_pkg::CMD_ENTER_PGM: begin
							if (!pm_q) begin
								res[0] = stk_isp_pkg::mk_line(stk_isp_pkg::OK_RESET, ah);
								res[1] = stk_isp_pkg::mk_line(stk_isp_pkg::OK_SPIEN, 1'b1);
								res[2] = stk_isp_pkg::mk_line(stk_isp_pkg::OK_RESET, !ah);
								res[3] = stk_isp_pkg::mk_line(stk_isp_pkg::OK_RESET, ah);
								res[4] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_PGM_EN,
									stk_isp_pkg::SPI_PGM_EN2, 8'h00, 8'h00);
								rn = 4'd5;
								phase_n = PH_SPI_PMODE;
							end else begin
								phase_n = PH_EOP_EMPTY;
							end
						end
						stk_isp_pkg::CMD_LEAVE_PGM: begin
							err_n = '0;
							res[0] = stk_isp_pkg::mk_line(stk_isp_pkg::OK_SPIEN, 1'b0);
							res[1] = stk_isp_pkg::mk_line(stk_isp_pkg::OK_RESET, ah);
							rn = 4'd2;
							pm_n = 1'b0;
							phase_n = PH_EOP_EMPTY;
						end
						stk_isp_pkg::CMD_LOAD_ADDR: phase_n = PH_ADDR_LO;
						stk_isp_pkg::CMD_PROG_FL: begin
							bi_n = 16'd2;
							bidx_n = AW'(2);
							phase_n = PH_SKIP;
						end
						stk_isp_pkg::CMD_PROG_DATA: begin
							bi_n = 16'd1;
							bidx_n = AW'(1);
							phase_n = PH_SKIP;
						end
						stk_isp_pkg::CMD_PROG_PAGE, stk_isp_pkg::CMD_READ_PAGE:
							phase_n = PH_LEN_HI;
						stk_isp_pkg::CMD_READ_SIG: phase_n = PH_EOP_SIG;
						stk_isp_pkg::EOP: begin
							err_n = err_q + 16'd1;
							res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_NOSYNC);
							rn = 4'd1;
							phase_n = PH_IDLE;
						end
						default: begin
							err_n = err_q + 16'd1;
							phase_n = PH_EOP_UNKNOWN;
						end
					endcase
				end
				PH_EOP_EMPTY: begin
					if (d == stk_isp_pkg::EOP) begin
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_INSYNC);
						res[1] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
						rn = 4'd2;
					end else begin
						err_n = err_q + 16'd1;
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_NOSYNC);
						rn = 4'd1;
					end
					phase_n = PH_IDLE;
				end
				PH_EOP_BYTE, PH_EOP_EEPROM: begin
					if (d == stk_isp_pkg::EOP) begin
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_INSYNC);
						res[1] = stk_isp_pkg::mk_host(held_q);
						rn = 4'd2;
						if (phase_q == PH_EOP_BYTE) begin
							res[2] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
							rn = 4'd3;
						end
					end else begin
						err_n = err_q + 16'd1;
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_NOSYNC);
						rn = 4'd1;
					end
					phase_n = PH_IDLE;
				end
				PH_EOP_ID: begin
					if (d == stk_isp_pkg::EOP) begin
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_INSYNC);
						for (int i = 0; i < 7; i++) begin
							res[i+1] = stk_isp_pkg::mk_host(stk_isp_pkg::id_char(3'(i)));
						end
						res[8] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
						rn = 4'd9;
					end else begin
						err_n = err_q + 16'd1;
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_NOSYNC);
						rn = 4'd1;
					end
					phase_n = PH_IDLE;
				end
				PH_VER: begin
					case (d)
						stk_isp_pkg::PARM_HW:    held_n = hw_q;
						stk_isp_pkg::PARM_SWMAJ: held_n = swmaj_q;
						stk_isp_pkg::PARM_SWMIN: held_n = swmin_q;
						stk_isp_pkg::PARM_PTYPE: held_n = 8'h53;
						default:                 held_n = 8'h00;
					endcase
					phase_n = PH_EOP_BYTE;
				end
				PH_FILL: begin
					bi_n = bi_q + 16'd1;
					bidx_n = wrap_inc(bidx_q, 2'd1);
					if (bi_n >= fill_tgt(cmd_q, mk_q, tl_q)) begin
						fd = 1'b1;
					end
				end
				PH_ADDR_LO: begin
					wa_n = {8'h00, d};
					phase_n = PH_ADDR_HI;
				end
				PH_ADDR_HI: begin
					wa_n = wa_q + {d, 8'h00};
					phase_n = PH_EOP_EMPTY;
				end
				PH_SKIP: begin
					bi_n = bi_q - 16'd1;
					bidx_n = wrap_dec(bidx_q);
					if (bi_n == '0) begin
						phase_n = PH_EOP_EMPTY;
					end
				end
				PH_LEN_HI: begin
					tl_n = {d, 8'h00};
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					tl_n = tl_q | {8'h00, d};
					phase_n = PH_MEMTYPE;
				end
				PH_MEMTYPE: begin
					mk_n = (d == 8'h46) ? stk_isp_pkg::MEM_FLASH :
						(d == 8'h45) ? stk_isp_pkg::MEM_EEPROM : stk_isp_pkg::MEM_NONE;
					if (cmd_q == stk_isp_pkg::CMD_READ_PAGE) begin
						phase_n = PH_EOP_READ;
					end else if (mk_n == stk_isp_pkg::MEM_FLASH) begin
						sf = 1'b1;
					end else if (mk_n == stk_isp_pkg::MEM_EEPROM) begin
						if (tl_q > es_q) begin
							err_n = err_q + 16'd1;
							held_n = stk_isp_pkg::R_FAILED;
							phase_n = PH_EOP_EEPROM;
						end else begin
							cs_n = {wa_q[14:0], 1'b0};
							sf = 1'b1;
						end
					end else begin
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_FAILED);
						rn = 4'd1;
						phase_n = PH_IDLE;
					end
				end
				PH_EOP_READ: begin
					if (d != stk_isp_pkg::EOP) begin
						err_n = err_q + 16'd1;
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_NOSYNC);
						rn = 4'd1;
						phase_n = PH_IDLE;
					end else begin
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_INSYNC);
						rn = 4'd1;
						bi_n = '0;
						bidx_n = '0;
						phase_n = PH_IDLE;
						if (mk_q == stk_isp_pkg::MEM_FLASH) begin
							if (tl_q != '0) begin
								res[1] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_RD_LO, wa_q[15:8],
									wa_q[7:0], 8'h00);
								phase_n = PH_FR_LO;
							end else begin
								res[1] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
							end
						end else if (mk_q == stk_isp_pkg::MEM_EEPROM) begin
							cs_n = {wa_q[14:0], 1'b0};
							if (tl_q != '0) begin
								res[1] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_EE_RD, cs_n[15:8],
									cs_n[7:0], 8'hFF);
								phase_n = PH_ER;
							end else begin
								res[1] = stk_isp_pkg::mk_host(stk_isp_pkg::R_OK);
							end
						end else begin
							res[1] = stk_isp_pkg::mk_host(stk_isp_pkg::R_FAILED);
						end
						rn = 4'd2;
					end
				end
				PH_EOP_SIG: begin
					if (d != stk_isp_pkg::EOP) begin
						err_n = err_q + 16'd1;
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_NOSYNC);
						rn = 4'd1;
						phase_n = PH_IDLE;
					end else begin
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_INSYNC);
						res[1] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_SIG, 8'h00, 8'h00, 8'h00);
						rn = 4'd2;
						bi_n = '0;
						bidx_n = '0;
						phase_n = PH_SIG;
					end
				end
				PH_EOP_UNKNOWN: begin
					res[0] = stk_isp_pkg::mk_host((d == stk_isp_pkg::EOP) ?
						stk_isp_pkg::R_UNKNOWN : stk_isp_pkg::R_NOSYNC);
					rn = 4'd1;
					phase_n = PH_IDLE;
				end
				PH_EOP_FLASH: begin
					if (d != stk_isp_pkg::EOP) begin
						err_n = err_q + 16'd1;
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_NOSYNC);
						rn = 4'd1;
						phase_n = PH_IDLE;
					end else begin
						res[0] = stk_isp_pkg::mk_host(stk_isp_pkg::R_INSYNC);
						op_n = cur_page(ps_q, wa_q);
						bi_n = '0;
						bidx_n = '0;
						if (tl_q != '0) begin
							res[1] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_LD_LO, wa_q[15:8],
								wa_q[7:0], rd_byte);
							phase_n = PH_FW_LO;
						end else begin
							res[1] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_COMMIT, op_n[15:8],
								op_n[7:0], 8'h00);
							phase_n = PH_FW_FINAL;
						end
						rn = 4'd2;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end

		if (sf) begin
			bi_n = '0;
			bidx_n = '0;
			phase_n = PH_FILL;
			if (fill_tgt(cmd_n, mk_n, tl_n) == '0) begin
				fd = 1'b1;
			end
		end

		if (fd) begin
			case (cmd_n)
				stk_isp_pkg::CMD_SET_DEV: begin
					dev_n = pbw[0];
					ps_n = {pbw[4], pbw[5]};
					es_n = {pbw[6], pbw[7]};
					phase_n = PH_EOP_EMPTY;
				end
				stk_isp_pkg::CMD_SET_DEVX: phase_n = PH_EOP_EMPTY;
				stk_isp_pkg::CMD_UNIVERSAL: begin
					res[rn] = stk_isp_pkg::mk_frame(pbw[0], pbw[1], pbw[2], pbw[3]);
					rn = rn + 4'd1;
					phase_n = PH_SPI_UNIV;
				end
				stk_isp_pkg::CMD_PROG_PAGE: begin
					if (mk_n == stk_isp_pkg::MEM_FLASH) begin
						phase_n = PH_EOP_FLASH;
					end else if (fill_tgt(cmd_n, mk_n, tl_n) == '0) begin
						held_n = stk_isp_pkg::R_OK;
						phase_n = PH_EOP_EEPROM;
					end else begin
						bi_n = '0;
						bidx_n = '0;
						res[rn] = stk_isp_pkg::mk_frame(stk_isp_pkg::SPI_EE_WR, cs_n[15:8],
							cs_n[7:0], buf0);
						rn = rn + 4'd1;
						phase_n = PH_EEW;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end

		if (rn != 4'd0) begin
			res[rn - 4'd1].last = 1'b1;
		end
		res_cnt = rn;
	end

	// next page buffer address each phase reads, kept fetched every cycle
	always_comb begin
		case (phase_n)
			PH_EOP_FLASH, PH_FILL: pred_ph_addr = '0;
			PH_FW_LO, PH_EEW:      pred_ph_addr = wrap_inc(bidx_n, 2'd1);
			PH_FW_HI:              pred_ph_addr = wrap_inc(bidx_n, 2'd2);
			default:               pred_ph_addr = bidx_n;
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_EOP_FLASH, PH_FILL: raddr = '0;
			PH_FW_LO, PH_EEW:      raddr = wrap_inc(bidx_q, 2'd1);
			PH_FW_HI:              raddr = wrap_inc(bidx_q, 2'd2);
			default:               raddr = bidx_q;
		endcase
		if (step_fire) begin
			raddr = pred_ph_addr;
		end
	end

	stk_isp_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_page_buf (
		.clk   (clk),
		.we    (step_fire && fill_we),
		.waddr (bidx_q),
		.wdata (in_data_s1),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		byp_d_q <= in_data_s1;
		if (step_fire) begin
			for (int i = 0; i < 8; i++) begin
				pb_q[i] <= pbw[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= step_fire && fill_we && (bidx_q == raddr);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_type_s1 <= s_axis_tuser;
			in_data_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= 8'd2;
			swmaj_q <= 8'd1;
			swmin_q <= 8'd18;
		end else if (cfg_we) begin
			case (cfg_index)
				stk_isp_pkg::CFG_HW:    hw_q <= cfg_wdata;
				stk_isp_pkg::CFG_SWMAJ: swmaj_q <= cfg_wdata;
				stk_isp_pkg::CFG_SWMIN: swmin_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			phase_q <= PH_IDLE;
			wa_q <= '0;
			bi_q <= '0;
			bidx_q <= '0;
			tl_q <= '0;
			mk_q <= stk_isp_pkg::MEM_NONE;
			dev_q <= '0;
			ps_q <= '0;
			es_q <= '0;
			err_q <= '0;
			pm_q <= 1'b0;
			op_q <= '0;
			cs_q <= '0;
			held_q <= '0;
		end else if (step_fire) begin
			cmd_q <= cmd_n;
			phase_q <= phase_n;
			wa_q <= wa_n;
			bi_q <= bi_n;
			bidx_q <= bidx_n;
			tl_q <= tl_n;
			mk_q <= mk_n;
			dev_q <= dev_n;
			ps_q <= ps_n;
			es_q <= es_n;
			err_q <= err_n;
			pm_q <= pm_n;
			op_q <= op_n;
			cs_q <= cs_n;
			held_q <= held_n;
		end
	end

	// result buffer: load on a step, shift out one per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_cnt_q <= '0;
		end else if (step_fire) begin
			obuf_cnt_q <= res_cnt;
		end else if (m_fire) begin
			obuf_cnt_q <= obuf_cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			for (int i = 0; i < NR; i++) begin
				obuf_q[i] <= res[i];
			end
		end else if (m_fire) begin
			for (int i = 0; i < NR - 1; i++) begin
				obuf_q[i] <= obuf_q[i+1];
			end
		end
	end

	assign m_axis_tdata = {7'b0, obuf_q[0].lvl, obuf_q[0].b3, obuf_q[0].b2, obuf_q[0].b1,
		obuf_q[0].b0, obuf_q[0].hb};
	assign m_axis_tuser = obuf_q[0].kind;
	assign m_axis_tlast = obuf_q[0].last;

	`ISP_ASSERT_IMP(a_obuf_bound, 1'b1, obuf_cnt_q <= 4'(NR), "result buffer overfilled")
	`ISP_ASSERT_NXT(a_res_shown, step_fire && res_cnt != 4'd0, m_axis_tvalid, "results lost")
	`ISP_ASSERT_IMP(a_last_end, m_axis_tvalid && m_axis_tlast, obuf_cnt_q == 4'd1, "tlast early")

endmodule

FILE: verif/stk500v1_isp_command_engine_core_checker.sv
`timescale 1ns / 100ps

module stk500v1_isp_command_engine_core_checker
	import stk_isp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	output int          fail_count,
	output int          pending,
	output logic        awaiting,
	output logic        at_idle,
	output logic        len_hi
);

	typedef enum logic [4:0] {
		P_IDLE, P_EOP_EMPTY, P_EOP_BYTE, P_EOP_ID, P_VER, P_FILL, P_ADDR_LO, P_ADDR_HI,
		P_SKIP, P_LEN_HI, P_LEN_LO, P_MEMTYPE, P_EOP_READ, P_EOP_SIG, P_EOP_UNK,
		P_EOP_FLASH, P_EOP_EEPROM, P_SPI_PMODE, P_SPI_UNIV, P_FW_LO, P_FW_HI,
		P_FW_COMMIT, P_FW_FINAL, P_EEW, P_FR_LO, P_FR_HI, P_ER, P_SIG
	} isp_phase_e;

	localparam logic [7:0]  PTYPE_ANSWER = 8'h53;
	localparam logic [55:0] SIGN_ON_TEXT = 56'h41_56_52_20_49_53_50;

	logic [7:0]  hw_ver, sw_maj, sw_min, cmd, held, dev;
	isp_phase_e  ph;
	logic [15:0] wa, bi, tlen, psz, esz, errc, opage, cstart;
	logic [1:0]  mkind;
	logic        pm;
	logic [7:0]  pbuf [0:255];
	res_t        step_results[$];
	res_t        pending_results[$];

	task automatic emit(input logic [1:0] k, input logic [7:0] hb, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c, input logic [7:0] d, input logic l);
		res_t r;
		if (step_results.size() >= MAX_RES) return;
		r = '0;
		r.kind = k;
		r.hb = hb;
		r.b0 = a;
		r.b1 = b;
		r.b2 = c;
		r.b3 = d;
		r.lvl = l;
		step_results.push_back(r);
	endtask

	task automatic host_out(input logic [7:0] b);
		emit(OK_HOST, b, 0, 0, 0, 0, 0);
	endtask

	task automatic frame_out(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
		input logic [7:0] d);
		emit(OK_FRAME, 0, a, b, c, d, 0);
	endtask

	task automatic line_out(input logic [1:0] k, input logic l);
		emit(k, 0, 0, 0, 0, 0, l);
	endtask

	function automatic logic reset_level(input logic asrt);
		return asrt == (dev >= 8'hE0);
	endfunction

	function automatic logic [15:0] cur_page();
		case (psz)
			16'd32:  return wa & 16'hFFF0;
			16'd64:  return wa & 16'hFFE0;
			16'd128: return wa & 16'hFFC0;
			16'd256: return wa & 16'hFF80;
			default: return wa;
		endcase
	endfunction

	function automatic logic [15:0] fill_target();
		if (cmd == CMD_PROG_PAGE && mkind == MEM_EEPROM)
			return (tlen > DEF_EEPROM_CHUNK) ? 16'(DEF_EEPROM_CHUNK) : tlen;
		return tlen;
	endfunction

	task automatic bad_sync();
		errc++;
		host_out(R_NOSYNC);
		ph = P_IDLE;
	endtask

	task automatic eew_frame();
		logic [15:0] a;
		a = cstart + bi;
		frame_out(SPI_EE_WR, a[15:8], a[7:0], pbuf[bi[7:0]]);
		ph = P_EEW;
	endtask

	task automatic er_frame();
		logic [15:0] a;
		a = cstart + bi;
		frame_out(SPI_EE_RD, a[15:8], a[7:0], 8'hFF);
		ph = P_ER;
	endtask

	task automatic fw_low();
		frame_out(SPI_LD_LO, wa[15:8], wa[7:0], pbuf[bi[7:0]]);
		ph = P_FW_LO;
	endtask

	task automatic fw_high();
		logic [7:0] i;
		i = bi[7:0] + 8'd1;
		frame_out(SPI_LD_HI, wa[15:8], wa[7:0], pbuf[i]);
		ph = P_FW_HI;
	endtask

	task automatic fw_commit(input logic fin);
		frame_out(SPI_COMMIT, opage[15:8], opage[7:0], 8'h00);
		ph = fin ? P_FW_FINAL : P_FW_COMMIT;
	endtask

	task automatic fr_low();
		frame_out(SPI_RD_LO, wa[15:8], wa[7:0], 8'h00);
		ph = P_FR_LO;
	endtask

	task automatic fr_high();
		frame_out(SPI_RD_HI, wa[15:8], wa[7:0], 8'h00);
		ph = P_FR_HI;
	endtask

	task automatic sig_frame();
		frame_out(SPI_SIG, 8'h00, bi[7:0], 8'h00);
		ph = P_SIG;
	endtask

	task automatic fill_done();
		case (cmd)
			CMD_SET_DEV: begin
				dev = pbuf[0];
				psz = {pbuf[12], pbuf[13]};
				esz = {pbuf[14], pbuf[15]};
				ph = P_EOP_EMPTY;
			end
			CMD_SET_DEVX: ph = P_EOP_EMPTY;
			CMD_UNIVERSAL: begin
				frame_out(pbuf[0], pbuf[1], pbuf[2], pbuf[3]);
				ph = P_SPI_UNIV;
			end
			CMD_PROG_PAGE: begin
				if (mkind == MEM_FLASH) begin
					ph = P_EOP_FLASH;
				end else if (fill_target() == 0) begin
					held = R_OK;
					ph = P_EOP_EEPROM;
				end else begin
					bi = 0;
					eew_frame();
				end
			end
			default: ph = P_IDLE;
		endcase
	endtask

	task automatic start_fill();
		bi = 0;
		ph = P_FILL;
		if (fill_target() == 0) fill_done();
	endtask

	task automatic on_command(input logic [7:0] d);
		cmd = d;
		case (d)
			CMD_SYNC: begin
				errc = 0;
				ph = P_EOP_EMPTY;
			end
			CMD_SIGN_ON: ph = P_EOP_ID;
			CMD_GET_PARM: ph = P_VER;
			CMD_SET_DEV: begin
				tlen = 20;
				start_fill();
			end
			CMD_SET_DEVX: begin
				tlen = 5;
				start_fill();
			end
			CMD_UNIVERSAL: begin
				tlen = 4;
				start_fill();
			end
			CMD_ENTER_PGM: begin
				if (!pm) begin
					line_out(OK_RESET, reset_level(1'b1));
					line_out(OK_SPIEN, 1'b1);
					line_out(OK_RESET, reset_level(1'b0));
					line_out(OK_RESET, reset_level(1'b1));
					frame_out(SPI_PGM_EN, SPI_PGM_EN2, 8'h00, 8'h00);
					ph = P_SPI_PMODE;
				end else begin
					ph = P_EOP_EMPTY;
				end
			end
			CMD_LEAVE_PGM: begin
				errc = 0;
				line_out(OK_SPIEN, 1'b0);
				line_out(OK_RESET, reset_level(1'b1));
				pm = 0;
				ph = P_EOP_EMPTY;
			end
			CMD_LOAD_ADDR: ph = P_ADDR_LO;
			CMD_PROG_FL: begin
				bi = 2;
				ph = P_SKIP;
			end
			CMD_PROG_DATA: begin
				bi = 1;
				ph = P_SKIP;
			end
			CMD_PROG_PAGE, CMD_READ_PAGE: ph = P_LEN_HI;
			CMD_READ_SIG: ph = P_EOP_SIG;
			EOP: bad_sync();
			default: begin
				errc++;
				ph = P_EOP_UNK;
			end
		endcase
	endtask

	task automatic on_host(input logic [7:0] d);
		case (ph)
			P_IDLE: on_command(d);
			P_EOP_EMPTY: begin
				if (d == EOP) begin
					host_out(R_INSYNC);
					host_out(R_OK);
					ph = P_IDLE;
				end else begin
					bad_sync();
				end
			end
			P_EOP_BYTE, P_EOP_EEPROM: begin
				if (d != EOP) begin
					bad_sync();
				end else begin
					host_out(R_INSYNC);
					host_out(held);
					if (ph == P_EOP_BYTE) host_out(R_OK);
					ph = P_IDLE;
				end
			end
			P_EOP_ID: begin
				if (d != EOP) begin
					bad_sync();
				end else begin
					host_out(R_INSYNC);
					for (int i = 0; i < 7; i++) host_out(SIGN_ON_TEXT[55 - 8 * i -: 8]);
					host_out(R_OK);
					ph = P_IDLE;
				end
			end
			P_VER: begin
				held = (d == PARM_HW) ? hw_ver : (d == PARM_SWMAJ) ? sw_maj :
					(d == PARM_SWMIN) ? sw_min : (d == PARM_PTYPE) ? PTYPE_ANSWER : 8'h00;
				ph = P_EOP_BYTE;
			end
			P_FILL: begin
				pbuf[bi[7:0]] = d;
				bi++;
				if (bi >= fill_target()) fill_done();
			end
			P_ADDR_LO: begin
				wa = {8'h00, d};
				ph = P_ADDR_HI;
			end
			P_ADDR_HI: begin
				wa = wa + {d, 8'h00};
				ph = P_EOP_EMPTY;
			end
			P_SKIP: begin
				bi--;
				if (bi == 0) ph = P_EOP_EMPTY;
			end
			P_LEN_HI: begin
				tlen = {d, 8'h00};
				ph = P_LEN_LO;
			end
			P_LEN_LO: begin
				tlen = tlen | {8'h00, d};
				ph = P_MEMTYPE;
			end
			P_MEMTYPE: begin
				mkind = (d == 8'h46) ? MEM_FLASH : (d == 8'h45) ? MEM_EEPROM : MEM_NONE;
				if (cmd == CMD_READ_PAGE) begin
					ph = P_EOP_READ;
				end else if (mkind == MEM_FLASH) begin
					start_fill();
				end else if (mkind == MEM_EEPROM) begin
					if (tlen > esz) begin
						errc++;
						held = R_FAILED;
						ph = P_EOP_EEPROM;
					end else begin
						cstart = {wa[14:0], 1'b0};
						start_fill();
					end
				end else begin
					host_out(R_FAILED);
					ph = P_IDLE;
				end
			end
			P_EOP_READ: begin
				if (d != EOP) begin
					bad_sync();
				end else begin
					host_out(R_INSYNC);
					bi = 0;
					ph = P_IDLE;
					if (mkind == MEM_FLASH) begin
						if (tlen > 0) fr_low();
						else host_out(R_OK);
					end else if (mkind == MEM_EEPROM) begin
						cstart = {wa[14:0], 1'b0};
						if (tlen > 0) er_frame();
						else host_out(R_OK);
					end else begin
						host_out(R_FAILED);
					end
				end
			end
			P_EOP_SIG: begin
				if (d != EOP) begin
					bad_sync();
				end else begin
					host_out(R_INSYNC);
					bi = 0;
					sig_frame();
				end
			end
			P_EOP_UNK: begin
				host_out((d == EOP) ? R_UNKNOWN : R_NOSYNC);
				ph = P_IDLE;
			end
			P_EOP_FLASH: begin
				if (d != EOP) begin
					bad_sync();
				end else begin
					host_out(R_INSYNC);
					opage = cur_page();
					bi = 0;
					if (tlen > 0) fw_low();
					else fw_commit(1'b1);
				end
			end
			default: ph = P_IDLE;
		endcase
	endtask

	task automatic on_reply(input logic [7:0] d);
		case (ph)
			P_SPI_PMODE: begin
				pm = 1;
				ph = P_EOP_EMPTY;
			end
			P_SPI_UNIV: begin
				held = d;
				ph = P_EOP_BYTE;
			end
			P_FW_LO: fw_high();
			P_FW_HI: begin
				wa++;
				if (17'(bi) + 17'd2 < 17'(tlen)) begin
					bi = bi + 16'd2;
					if (opage != cur_page()) fw_commit(1'b0);
					else fw_low();
				end else begin
					fw_commit(1'b1);
				end
			end
			P_FW_COMMIT: begin
				opage = cur_page();
				fw_low();
			end
			P_FW_FINAL: begin
				host_out(R_OK);
				ph = P_IDLE;
			end
			P_EEW: begin
				bi++;
				if (bi < fill_target()) begin
					eew_frame();
				end else if (tlen > DEF_EEPROM_CHUNK) begin
					tlen = tlen - 16'(DEF_EEPROM_CHUNK);
					cstart = cstart + 16'(DEF_EEPROM_CHUNK);
					start_fill();
				end else begin
					held = R_OK;
					ph = P_EOP_EEPROM;
				end
			end
			P_FR_LO: begin
				host_out(d);
				fr_high();
			end
			P_FR_HI: begin
				host_out(d);
				wa++;
				if (17'(bi) + 17'd2 < 17'(tlen)) begin
					bi = bi + 16'd2;
					fr_low();
				end else begin
					host_out(R_OK);
					ph = P_IDLE;
				end
			end
			P_ER: begin
				host_out(d);
				bi++;
				if (bi < tlen) er_frame();
				else begin
					host_out(R_OK);
					ph = P_IDLE;
				end
			end
			P_SIG: begin
				host_out(d);
				bi++;
				if (bi < 3) sig_frame();
				else begin
					host_out(R_OK);
					ph = P_IDLE;
				end
			end
			default: ph = P_IDLE;
		endcase
	endtask

	task automatic isp_step(input logic req, input logic [7:0] d);
		step_results.delete();
		// a byte of the wrong kind for the phase is dropped
		if (req && ph >= P_SPI_PMODE) on_reply(d);
		else if (!req && ph < P_SPI_PMODE) on_host(d);
		if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i]) pending_results.push_back(step_results[i]);
	endtask

	task automatic check_result();
		res_t got, want;
		got.kind = m_axis_tuser;
		got.hb = m_axis_tdata[7:0];
		got.b0 = m_axis_tdata[15:8];
		got.b1 = m_axis_tdata[23:16];
		got.b2 = m_axis_tdata[31:24];
		got.b3 = m_axis_tdata[39:32];
		got.lvl = m_axis_tdata[40];
		got.last = m_axis_tlast;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result kind=%0d hb=%h frame=%h %h %h %h lvl=%b last=%b",
					got.kind, got.hb, got.b0, got.b1, got.b2, got.b3, got.lvl, got.last);
			return;
		end
		want = pending_results.pop_front();
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch exp kind=%0d hb=%h frame=%h %h %h %h lvl=%b last=%b | act kind=%0d hb=%h frame=%h %h %h %h lvl=%b last=%b",
					want.kind, want.hb, want.b0, want.b1, want.b2, want.b3, want.lvl,
					want.last, got.kind, got.hb, got.b0, got.b1, got.b2, got.b3, got.lvl,
					got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_ver = 8'd2;
			sw_maj = 8'd1;
			sw_min = 8'd18;
			cmd = 0;
			held = 0;
			dev = 0;
			ph = P_IDLE;
			{wa, bi, tlen, psz, esz, errc, opage, cstart} = '0;
			mkind = MEM_NONE;
			pm = 0;
			for (int i = 0; i < 256; i++) pbuf[i] = 8'h00;
			pending_results.delete();
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) check_result();
			if (cfg_we) begin
				case (cfg_index)
					CFG_HW:    hw_ver = cfg_wdata;
					CFG_SWMAJ: sw_maj = cfg_wdata;
					CFG_SWMIN: sw_min = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) isp_step(s_axis_tuser, s_axis_tdata);
		end
		pending = pending_results.size();
		awaiting = ph >= P_SPI_PMODE;
		at_idle = ph == P_IDLE;
		len_hi = ph == P_LEN_HI;
	end

endmodule

FILE: verif/stk500v1_isp_command_engine_core_tb.sv
`timescale 1ns / 100ps

module stk500v1_isp_command_engine_core_tb;
	import stk_isp_pkg::*;

	localparam int RANDOM_ITEMS = 160;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [7:0] MT_FLASH = 8'h46;
	localparam logic [7:0] MT_EEPROM = 8'h45;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_HW;
	logic [7:0]  cfg_wdata = 8'h00;

	int   fail_count, pending;
	logic awaiting, at_idle, len_hi;
	int   sent = 0;
	int   cycles = 0;
	bit   calm = 0;
	bit   wr_mask [0:255];
	logic [7:0] host_q[$];

	stk500v1_isp_command_engine_core dut (.*);

	stk500v1_isp_command_engine_core_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("stk500v1_isp_command_engine_core test failed");
			$finish;
		end
	end

	// flip between bursts with and without idling
	always begin
		repeat (300) @(posedge clk);
		calm = ($urandom % 4) == 0;
	end

	initial begin : receiver
		int stall;
		int hold;
		bit held;
		stall = 0;
		hold = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else if (!held && sent >= 80) begin
				// long hold-off so the output buffer fills and stalls the input
				held = 1;
				hold = 400;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				case ($urandom % 100) inside
					[0:7]:   stall = $urandom_range(1, 3);
					[8:9]:   stall = $urandom_range(10, 30);
					default: stall = 0;
				endcase
				m_axis_tready <= (stall == 0);
			end
		end
	end

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom % 100;
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// starts and ends at a falling edge
	task automatic xfer(input logic req, input logic [7:0] b);
		repeat (gap_len() + 1) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		sent++;
		@(negedge clk);
	endtask

	// send queued host bytes, answering every awaited SPI frame
	task automatic run_cmd();
		while (host_q.size() > 0 || awaiting) begin
			if (awaiting) begin
				if ($urandom % 25 == 0) xfer(1'b0, $urandom);
				else xfer(1'b1, $urandom);
			end else begin
				if ($urandom % 25 == 0) xfer(1'b1, $urandom);
				xfer(1'b0, host_q.pop_front());
			end
		end
	endtask

	task automatic mark_fill(input int n);
		for (int i = 0; i < n; i++) wr_mask[i % 256] = 1;
	endtask

	task automatic set_device(input logic [7:0] dv, input logic [15:0] ps, input logic [15:0] es);
		host_q.push_back(CMD_SET_DEV);
		for (int i = 0; i < 20; i++) begin
			case (i)
				0: host_q.push_back(dv);
				12: host_q.push_back(ps[15:8]);
				13: host_q.push_back(ps[7:0]);
				14: host_q.push_back(es[15:8]);
				15: host_q.push_back(es[7:0]);
				default: host_q.push_back($urandom);
			endcase
		end
		host_q.push_back(EOP);
		mark_fill(20);
		run_cmd();
	endtask

	task automatic random_device();
		logic [15:0] ps, es;
		case ($urandom % 5)
			0: ps = 16'd32;
			1: ps = 16'd64;
			2: ps = 16'd128;
			3: ps = 16'd256;
			default: ps = $urandom;
		endcase
		es = ($urandom % 8 == 0) ? 16'hFFFF : 16'($urandom_range(0, 80));
		set_device(($urandom % 2) ? 8'($urandom_range(8'hE0, 8'hFF)) : 8'($urandom), ps, es);
	endtask

	task automatic simple(input logic [7:0] c);
		host_q.push_back(c);
		host_q.push_back(EOP);
		run_cmd();
	endtask

	task automatic get_parm(input logic [7:0] p);
		host_q = '{CMD_GET_PARM, p, EOP};
		run_cmd();
	endtask

	task automatic load_addr(input logic [15:0] a);
		host_q = '{CMD_LOAD_ADDR, a[7:0], a[15:8], EOP};
		run_cmd();
	endtask

	task automatic universal();
		host_q = '{CMD_UNIVERSAL, $urandom, $urandom, $urandom, $urandom, EOP};
		mark_fill(4);
		run_cmd();
	endtask

	task automatic flash_write(input int len);
		// an odd length reads one entry past the data: keep it to written entries
		if (len[0] && len < 256 && !wr_mask[len]) len = len & ~1;
		host_q = '{CMD_PROG_PAGE, 8'(len >> 8), 8'(len), MT_FLASH};
		for (int i = 0; i < len; i++) host_q.push_back($urandom);
		host_q.push_back(EOP);
		mark_fill(len);
		run_cmd();
	endtask

	task automatic eeprom_write(input int len, input int esz);
		host_q = '{CMD_PROG_PAGE, 8'(len >> 8), 8'(len), MT_EEPROM};
		if (len <= esz) begin
			for (int i = 0; i < len; i++) host_q.push_back($urandom);
			mark_fill((len > DEF_EEPROM_CHUNK) ? DEF_EEPROM_CHUNK : len);
		end
		host_q.push_back(EOP);
		run_cmd();
	endtask

	task automatic page_read(input int len, input logic [7:0] mt);
		host_q = '{CMD_READ_PAGE, 8'(len >> 8), 8'(len), mt, EOP};
		run_cmd();
	endtask

	task automatic bad_memtype_write();
		logic [7:0] mt;
		mt = $urandom;
		if (mt == MT_FLASH || mt == MT_EEPROM) mt = 8'h00;
		host_q = '{CMD_PROG_PAGE, 8'h00, 8'($urandom_range(0, 20)), mt};
		run_cmd();
	endtask

	// random bytes of both kinds, then drive the engine back to idle and set the device again
	task automatic noise(inout int esz);
		logic [7:0] b;
		repeat ($urandom_range(1, 8)) begin
			b = len_hi ? 8'h00 : 8'($urandom);
			// a page write here could read buffer entries that were never filled
			if (b == CMD_PROG_PAGE) b = 8'h00;
			xfer($urandom % 4 == 0, b);
		end
		while (!at_idle || awaiting) begin
			if (awaiting) xfer(1'b1, $urandom);
			else xfer(1'b0, EOP);
		end
		esz = 64;
		set_device($urandom, 16'd64, 16'd64);
	endtask

	task automatic wait_quiet();
		do @(negedge clk); while (pending != 0 || awaiting || !at_idle);
		repeat (20) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
	endtask

	task automatic cfg_all(input logic [7:0] h, input logic [7:0] ma, input logic [7:0] mi);
		cfg_write(CFG_HW, h);
		cfg_write(CFG_SWMAJ, ma);
		cfg_write(CFG_SWMIN, mi);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int esz;
		int target;
		for (int i = 0; i < 256; i++) wr_mask[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		get_parm(PARM_HW);
		wait_quiet();
		cfg_all(8'h00, 8'hFF, 8'h00);
		simple(CMD_SYNC);
		simple(CMD_SIGN_ON);
		get_parm(PARM_HW);
		get_parm(PARM_SWMAJ);
		get_parm(PARM_SWMIN);
		get_parm(PARM_PTYPE);
		get_parm(8'h00);
		esz = 64;
		set_device(8'hE0, 16'd64, 16'd64);
		simple(CMD_ENTER_PGM);
		simple(CMD_ENTER_PGM);
		load_addr(16'hFFFF);
		universal();
		flash_write(3);
		page_read(4, MT_FLASH);
		eeprom_write(2, esz);
		eeprom_write(100, esz);
		page_read(2, MT_EEPROM);
		page_read(2, 8'h00);
		bad_memtype_write();
		simple(CMD_READ_SIG);
		simple(8'h99);
		host_q = '{EOP};
		run_cmd();
		host_q = '{CMD_SYNC, 8'h00};
		run_cmd();
		simple(CMD_LEAVE_PGM);
		set_device(8'h00, 16'd32, 16'd64);
		simple(CMD_ENTER_PGM);

		// random part in four settings of the version registers
		for (int seg = 0; seg < 4; seg++) begin
			wait_quiet();
			case (seg)
				0: cfg_all(8'hFF, 8'h00, 8'hFF);
				1: cfg_all(8'h00, 8'h00, 8'h00);
				2: cfg_all(8'hFF, 8'hFF, 8'hFF);
				default: cfg_all($urandom, $urandom, $urandom);
			endcase
			target = sent + RANDOM_ITEMS / 4;
			while (sent < target) begin
				case ($urandom % 20)
					0: simple(CMD_SYNC);
					1: simple(CMD_SIGN_ON);
					2, 3: get_parm(($urandom % 5 == 0) ? 8'($urandom) :
						8'(PARM_HW + $urandom_range(0, 2)));
					4: begin
						random_device();
						esz = -1;
					end
					5: simple(($urandom % 2) ? CMD_ENTER_PGM : CMD_LEAVE_PGM);
					6, 7: load_addr(($urandom % 2) ? 16'($urandom) : 16'($urandom_range(0, 300)));
					8: universal();
					9: begin
						host_q = '{CMD_PROG_FL, $urandom, $urandom, EOP};
						run_cmd();
					end
					10: begin
						host_q = '{CMD_PROG_DATA, $urandom, EOP};
						run_cmd();
					end
					11, 12: flash_write(($urandom % 100 < 90) ? $urandom_range(0, 16) :
						$urandom_range(17, 300));
					13: begin
						if (esz < 0) begin
							esz = 64;
							set_device($urandom, 16'd128, 16'd64);
						end
						eeprom_write(($urandom % 4 == 0) ? $urandom_range(33, 80) :
							$urandom_range(0, 32), esz);
					end
					14: page_read($urandom_range(0, 16), ($urandom % 2) ? MT_FLASH : MT_EEPROM);
					15: simple(CMD_READ_SIG);
					16: bad_memtype_write();
					default: begin
						noise(esz);
					end
				endcase
			end
		end

		do @(negedge clk); while (pending != 0 || awaiting);
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("stk500v1_isp_command_engine_core test passed");
		end else begin
			$display("stk500v1_isp_command_engine_core test failed");
		end
		$finish;
	end

endmodule
